/* sv/htep_pkg.sv */
// Package with the field widths and command codes of the Huffman table encoder and packer.
package htep_pkg;

  localparam int CMD_W     = 2;
  localparam int SYM_W     = 8;
  localparam int WORD_W    = 32;
  localparam int LEN_W     = 6;
  localparam int BYTE_W    = 8;
  localparam int IN_DATA_W = 48;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD   = 2'd0,
    CMD_ENCODE = 2'd1,
    CMD_FLUSH  = 2'd2
  } cmd_e;

endpackage

/* sv/huffman_table_encoder_packer.sv */
// Top level of the Huffman table encoder and bit packer.
// Input stream: tuser carries the command, tdata the symbol, code word and code length.
// A load transaction writes one code table entry and produces no output.
// An encode transaction looks up the symbol and packs its code, MSB first, into the
// pending byte; every completed byte leaves on the output stream, at most four.
// A flush transaction pads a partial pending byte with zeros and sends it.
// The output stream carries one packed byte per transaction; tlast marks the final
// byte caused by one input transaction.
// A load completes on acceptance, as does a flush with no partial byte pending; a flush
// with a partial byte passes through the flush state. An encode passes through the read
// state, which waits on the registered read of the table memory, and then packs each
// emitted byte, and a trailing partial byte, in the pack state.
// The first byte of an encode reaches the output register from the pack state.
// Reset empties the table (all code lengths read as zero) and clears the pending byte.
// A stalled receiver holds the output register; packing waits while it is full,
// and tready stays low until the current input transaction has finished.
module huffman_table_encoder_packer #(
  parameter int MAX_CODE_LEN = 32,
  parameter int SYMBOL_COUNT = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_tvalid_i,
  output logic                           s_tready_o,
  // symbol [7:0], code_bits [39:8], code_len [45:40], zero [47:46]
  input  logic [htep_pkg::IN_DATA_W-1:0] s_tdata_i,
  // cmd [1:0]
  input  logic [htep_pkg::CMD_W-1:0]     s_tuser_i,
  output logic                           m_tvalid_o,
  input  logic                           m_tready_i,
  // out_byte [7:0]
  output logic [htep_pkg::BYTE_W-1:0]    m_tdata_o,
  output logic                           m_tlast_o
);
  import htep_pkg::*;

  localparam int AddrW    = $clog2(SYMBOL_COUNT);
  localparam int LimitInt = (MAX_CODE_LEN < WORD_W) ? MAX_CODE_LEN : WORD_W;
  localparam logic [LEN_W-1:0] LenLimit = LEN_W'(LimitInt);

  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [WORD_W-1:0] word;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_PACK,
    ST_FLUSH
  } state_e;

  state_e              state_q;
  logic [BYTE_W-1:0]   pend_q;
  logic [2:0]          cnt_q;
  logic [LEN_W-1:0]    rem_q;
  logic [WORD_W-1:0]   code_q;
  logic                m_valid_q;
  logic [BYTE_W-1:0]   m_data_q;
  logic                m_last_q;

  entry_t              mem_q [SYMBOL_COUNT];
  entry_t              rd_q;
  logic [SYMBOL_COUNT-1:0] valid_q;
  logic                rd_valid_q;

  cmd_e                in_cmd;
  logic [SYM_W-1:0]    in_sym;
  logic [WORD_W-1:0]   in_bits;
  logic [LEN_W-1:0]    in_len;
  logic [LEN_W-1:0]    len_clamp;
  logic [AddrW-1:0]    addr;
  logic                accept;
  logic                sym_ok;
  logic                wr_en;

  logic [LEN_W-1:0]    rd_len;
  logic [WORD_W-1:0]   aligned;
  logic [3:0]          avail;
  logic [3:0]          k;
  logic [BYTE_W-1:0]   take;
  logic [BYTE_W-1:0]   pend_d;
  logic [3:0]          cnt_sum;
  logic [LEN_W-1:0]    rem_d;
  logic [BYTE_W-1:0]   flush_byte;
  logic                out_slot;

  assign in_cmd    = cmd_e'(s_tuser_i);
  assign in_sym    = s_tdata_i[SYM_W-1:0];
  assign in_bits   = s_tdata_i[SYM_W +: WORD_W];
  assign in_len    = s_tdata_i[SYM_W+WORD_W +: LEN_W];
  assign len_clamp = (in_len > LenLimit) ? LenLimit : in_len;
  assign addr      = in_sym[AddrW-1:0];
  assign sym_ok    = {1'b0, in_sym} < (SYM_W+1)'(SYMBOL_COUNT);

  assign s_tready_o = (state_q == ST_IDLE);
  assign accept     = s_tvalid_i && s_tready_o;
  assign wr_en      = accept && (in_cmd == CMD_LOAD) && sym_ok;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[addr] <= '{len: len_clamp, word: in_bits};
    end
    rd_q <= mem_q[addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_q[addr] <= 1'b1;
      end
      rd_valid_q <= valid_q[addr];
    end
  end

  always_comb begin
    rd_len     = rd_valid_q ? rd_q.len : '0;
    aligned    = rd_q.word << (LEN_W'(WORD_W) - rd_len);
    avail      = 4'(BYTE_W) - {1'b0, cnt_q};
    k          = (rem_q < {2'b00, avail}) ? rem_q[3:0] : avail;
    take       = code_q[WORD_W-1 -: BYTE_W] >> (4'(BYTE_W) - k);
    pend_d     = (pend_q << k) | take;
    cnt_sum    = {1'b0, cnt_q} + k;
    rem_d      = rem_q - {2'b00, k};
    flush_byte = pend_q << avail;
    out_slot   = !m_valid_q || m_tready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pend_q    <= '0;
      cnt_q     <= '0;
      rem_q     <= '0;
      code_q    <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
      m_last_q  <= 1'b0;
    end else begin
      if (m_tready_i) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            case (in_cmd)
              CMD_ENCODE: begin
                if (sym_ok) begin
                  state_q <= ST_READ;
                end
              end
              CMD_FLUSH: begin
                if (cnt_q != '0) begin
                  state_q <= ST_FLUSH;
                end
              end
              default: ;
            endcase
          end
        end
        ST_READ: begin
          if (rd_len == '0) begin
            state_q <= ST_IDLE;
          end else begin
            code_q  <= aligned;
            rem_q   <= rd_len;
            state_q <= ST_PACK;
          end
        end
        ST_PACK: begin
          if (cnt_sum == 4'(BYTE_W)) begin
            if (out_slot) begin
              m_valid_q <= 1'b1;
              m_data_q  <= pend_d;
              m_last_q  <= (rem_d < LEN_W'(BYTE_W));
              pend_q    <= '0;
              cnt_q     <= '0;
              code_q    <= code_q << k;
              rem_q     <= rem_d;
              if (rem_d == '0) begin
                state_q <= ST_IDLE;
              end
            end
          end else begin
            pend_q  <= pend_d;
            cnt_q   <= cnt_sum[2:0];
            rem_q   <= '0;
            state_q <= ST_IDLE;
          end
        end
        ST_FLUSH: begin
          if (out_slot) begin
            m_valid_q <= 1'b1;
            m_data_q  <= flush_byte;
            m_last_q  <= 1'b1;
            pend_q    <= '0;
            cnt_q     <= '0;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_data_q;
  assign m_tlast_o  = m_last_q;

endmodule

/* sv/htep_checker.sv */
// Port-level checker for the Huffman table encoder and packer, with its bind statement.
module htep_checker #(
  parameter int SYMBOL_COUNT = 256
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_tvalid_i,
  input logic                           s_tready_i,
  input logic [htep_pkg::IN_DATA_W-1:0] s_tdata_i,
  input logic [htep_pkg::CMD_W-1:0]     s_tuser_i,
  input logic                           m_tvalid_i,
  input logic                           m_tready_i,
  input logic [htep_pkg::BYTE_W-1:0]    m_tdata_i,
  input logic                           m_tlast_i
);
  import htep_pkg::*;

  logic s_acc;
  logic enc_hit;

  assign s_acc   = s_tvalid_i && s_tready_i;
  assign enc_hit = s_acc && (s_tuser_i == CMD_ENCODE) &&
                   ({1'b0, s_tdata_i[SYM_W-1:0]} < (SYM_W+1)'(SYMBOL_COUNT));

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> m_tvalid_i && $stable(m_tdata_i) && $stable(m_tlast_i))
    else $error("Output transaction changed while stalled.");

  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && (s_tuser_i == CMD_LOAD) && !m_tvalid_i |=> !m_tvalid_i)
    else $error("Load transaction produced an output byte.");

  a_encode_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    enc_hit |=> !s_tready_i)
    else $error("Input accepted during a table read.");

  a_more_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tlast_i |-> !s_tready_i)
    else $error("Input accepted before the final byte of an encode.");

endmodule

bind huffman_table_encoder_packer htep_checker #(
  .SYMBOL_COUNT(SYMBOL_COUNT)
) u_htep_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_tvalid_i),
  .s_tready_i (s_tready_o),
  .s_tdata_i  (s_tdata_i),
  .s_tuser_i  (s_tuser_i),
  .m_tvalid_i (m_tvalid_o),
  .m_tready_i (m_tready_i),
  .m_tdata_i  (m_tdata_o),
  .m_tlast_i  (m_tlast_o)
);

/* tb/tb_huffman_table_encoder_packer.sv */
// Self-checking testbench for the Huffman table encoder and bit packer.
`timescale 1ns / 1ps

module tb_huffman_table_encoder_packer;
  import htep_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int MAX_CODE_LEN   = 32;
  localparam int SYMBOL_COUNT   = 256;
  localparam int LEN_LIMIT      = (MAX_CODE_LEN < WORD_W) ? MAX_CODE_LEN : WORD_W;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 12;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [CMD_W-1:0] CMD_UNDEFINED = 2'd3;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } packed_beat_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [IN_DATA_W-1:0] s_tdata;
  logic [CMD_W-1:0]     s_tuser;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [BYTE_W-1:0]    m_tdata;
  logic                 m_tlast;

  logic [WORD_W-1:0] code_word_tbl [SYMBOL_COUNT];
  logic [LEN_W-1:0]  code_len_tbl  [SYMBOL_COUNT];
  bit                sym_loaded    [SYMBOL_COUNT];
  int                loaded_syms   [$];
  logic [BYTE_W-1:0] pend_byte;
  int                pend_count;
  packed_beat_t      packed_byte_q [$];

  int errors = 0;
  bit calm;
  int holds_asked;
  int holds_seen = 0;
  int hold_left = 0;
  int rx_gap = 0;
  int quiet_cycles = 0;

  huffman_table_encoder_packer #(
    .MAX_CODE_LEN(MAX_CODE_LEN),
    .SYMBOL_COUNT(SYMBOL_COUNT)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_tvalid),
    .s_tready_o(s_tready),
    .s_tdata_i (s_tdata),
    .s_tuser_i (s_tuser),
    .m_tvalid_o(m_tvalid),
    .m_tready_i(m_tready),
    .m_tdata_o (m_tdata),
    .m_tlast_o (m_tlast)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  task automatic pack_item(input logic [CMD_W-1:0] cmd, input logic [SYM_W-1:0] sym,
                           input logic [WORD_W-1:0] bits, input logic [LEN_W-1:0] len);
    int           first;
    int           clen;
    packed_beat_t beat;
    first = packed_byte_q.size();
    beat.last = 1'b0;
    if (cmd == CMD_LOAD) begin
      clen = (int'(len) > LEN_LIMIT) ? LEN_LIMIT : int'(len);
      code_word_tbl[sym] = bits;
      code_len_tbl[sym] = LEN_W'(clen);
      if (!sym_loaded[sym]) begin
        sym_loaded[sym] = 1'b1;
        loaded_syms.push_back(int'(sym));
      end
    end else if (cmd == CMD_ENCODE) begin
      clen = int'(code_len_tbl[sym]);
      for (int i = clen - 1; i >= 0; i--) begin
        pend_byte = {pend_byte[BYTE_W-2:0], code_word_tbl[sym][i]};
        pend_count++;
        if (pend_count == BYTE_W) begin
          beat.data = pend_byte;
          packed_byte_q.push_back(beat);
          pend_byte = '0;
          pend_count = 0;
        end
      end
    end else if (cmd == CMD_FLUSH) begin
      if (pend_count != 0) begin
        beat.data = pend_byte << (BYTE_W - pend_count);
        packed_byte_q.push_back(beat);
      end
      pend_byte = '0;
      pend_count = 0;
    end
    if (packed_byte_q.size() > first) begin
      beat = packed_byte_q.pop_back();
      beat.last = 1'b1;
      packed_byte_q.push_back(beat);
    end
  endtask

  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [SYM_W-1:0] sym,
                           input logic [WORD_W-1:0] bits, input logic [LEN_W-1:0] len);
    int gap;
    gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {2'b00, len, bits, sym};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    pack_item(cmd, sym, bits, len);
  endtask

  task automatic wait_for_drain();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (packed_byte_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_random_item();
    int          pick;
    int          r;
    logic [5:0]  len;
    logic [7:0]  sym;
    pick = $urandom_range(0, 99);
    if (pick < 25 || loaded_syms.size() == 0) begin
      r = $urandom_range(0, 9);
      if (r == 0)
        len = '0;
      else if (r == 1)
        len = LEN_W'($urandom_range(33, 63));
      else if (r < 4)
        len = LEN_W'($urandom_range(17, 32));
      else
        len = LEN_W'($urandom_range(1, 16));
      send_item(CMD_LOAD, SYM_W'($urandom_range(0, 255)), $urandom, len);
    end else if (pick < 80) begin
      sym = SYM_W'(loaded_syms[$urandom_range(0, loaded_syms.size() - 1)]);
      send_item(CMD_ENCODE, sym, $urandom, LEN_W'($urandom_range(0, 63)));
    end else if (pick < 92) begin
      send_item(CMD_FLUSH, SYM_W'($urandom_range(0, 255)), $urandom,
                LEN_W'($urandom_range(0, 63)));
    end else begin
      send_item(CMD_UNDEFINED, SYM_W'($urandom_range(0, 255)), $urandom,
                LEN_W'($urandom_range(0, 63)));
    end
  endtask

  task automatic test_directed();
    send_item(CMD_LOAD, 8'h00, 32'h0000_0001, 6'd1);
    send_item(CMD_LOAD, 8'hFF, 32'hFFFF_FFFF, 6'd32);
    send_item(CMD_LOAD, 8'hAA, 32'h0000_00A5, 6'd8);
    send_item(CMD_LOAD, 8'h55, 32'h0000_0005, 6'd3);
    send_item(CMD_LOAD, 8'h07, 32'hFFFF_FFFF, 6'd0);
    send_item(CMD_LOAD, 8'h80, 32'h1234_5678, 6'd63);
    send_item(CMD_LOAD, 8'h81, 32'hFFFF_FFFE, 6'd33);
    send_item(CMD_FLUSH, 8'h00, 32'h0, 6'd0);
    send_item(CMD_ENCODE, 8'hFF, 32'h0, 6'd0);
    send_item(CMD_ENCODE, 8'hAA, 32'h0, 6'd0);
    send_item(CMD_ENCODE, 8'h00, 32'h0, 6'd0);
    send_item(CMD_ENCODE, 8'h55, 32'h0, 6'd0);
    send_item(CMD_ENCODE, 8'h07, 32'h0, 6'd0);
    send_item(CMD_UNDEFINED, 8'hFF, 32'hFFFF_FFFF, 6'd63);
    send_item(CMD_FLUSH, 8'hFF, 32'hFFFF_FFFF, 6'd63);
    send_item(CMD_ENCODE, 8'h55, 32'h0, 6'd0);
    send_item(CMD_ENCODE, 8'h80, 32'h0, 6'd0);
    send_item(CMD_ENCODE, 8'h81, 32'h0, 6'd0);
    send_item(CMD_FLUSH, 8'h00, 32'h0, 6'd0);
    send_item(CMD_FLUSH, 8'h00, 32'h0, 6'd0);
    send_item(CMD_LOAD, 8'h00, 32'h0000_0000, 6'd1);
    send_item(CMD_ENCODE, 8'h00, 32'h0, 6'd0);
    send_item(CMD_ENCODE, 8'hFF, 32'h0, 6'd0);
    send_item(CMD_FLUSH, 8'h00, 32'h0, 6'd0);
  endtask

  task automatic test_random_stream();
    repeat (40) send_random_item();
  endtask

  // The receiver holds off while long codes keep arriving, so the input must stall.
  task automatic test_backpressure();
    send_item(CMD_LOAD, 8'hFF, $urandom, 6'd32);
    holds_asked <= holds_asked + 1;
    repeat (12) send_item(CMD_ENCODE, 8'hFF, 32'h0, 6'd0);
    send_item(CMD_ENCODE, 8'h55, 32'h0, 6'd0);
    send_item(CMD_FLUSH, 8'h00, 32'h0, 6'd0);
  endtask

  task automatic test_drain_pause();
    wait_for_drain();
    repeat (6) send_random_item();
    wait_for_drain();
    send_item(CMD_FLUSH, 8'h00, 32'h0, 6'd0);
  endtask

  task automatic test_no_idle();
    calm = 1'b1;
    repeat (20) send_random_item();
    send_item(CMD_FLUSH, 8'h00, 32'h0, 6'd0);
  endtask

  always @(posedge clk_i) begin
    if (holds_asked != holds_seen) begin
      holds_seen <= holds_asked;
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else if (rx_gap != 0) begin
      rx_gap <= rx_gap - 1;
      m_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      rx_gap <= $urandom_range(0, 12);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    packed_beat_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      if (packed_byte_q.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual byte %h last %b",
                 $time, m_tdata, m_tlast);
        errors++;
      end else begin
        want = packed_byte_q.pop_front();
        if (m_tdata !== want.data) begin
          $display("%0t: byte mismatch, expected %h, actual %h", $time, want.data, m_tdata);
          errors++;
        end
        if (m_tlast !== want.last) begin
          $display("%0t: last mismatch, expected %b, actual %b", $time, want.last, m_tlast);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired with %0d bytes outstanding", $time, packed_byte_q.size());
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni = 1'b0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    calm = 1'b0;
    holds_asked = 0;
    pend_byte = '0;
    pend_count = 0;
    for (int i = 0; i < SYMBOL_COUNT; i++) begin
      code_word_tbl[i] = '0;
      code_len_tbl[i] = '0;
      sym_loaded[i] = 1'b0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_directed();
    test_random_stream();
    test_backpressure();
    test_drain_pause();
    test_no_idle();

    s_tvalid <= 1'b0;
    while (packed_byte_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
